### src/keyed_record_table_compacting_top_assert.svh
// Assertion macros for the record table. Each macro expands to one labeled
// concurrent assertion clocked on clk and disabled during rst.
`ifndef KEYED_RECORD_TABLE_COMPACTING_TOP_ASSERT_SVH
`define KEYED_RECORD_TABLE_COMPACTING_TOP_ASSERT_SVH

// Same-cycle implication.
`define KR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kr_pkg.sv
package kr_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_FIND = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_MISS     = 3'd3,
    STAT_DELETED  = 3'd4,
    STAT_DEL_MISS = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  age;
    logic [23:0] cls;
    logic [63:0] name;
  } record_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic capture;
    logic add;
    logic del;
  } cell_ctrl_t;

  // Zero-terminated text: every byte after the first zero byte reads as zero.
  function automatic logic [63:0] cut_text(input logic [63:0] v);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (v[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) r[8*b +: 8] = v[8*b +: 8];
    end
    return r;
  endfunction

endpackage

### src/kr_if.sv
interface kr_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] key_id;
  logic [7:0]         age_in;
  logic [23:0]        class_in;
  logic [63:0]        name_in;

  modport source (output valid, func, key_id, age_in, class_in, name_in, input ready);
  modport sink (input valid, func, key_id, age_in, class_in, name_in, output ready);
endinterface

interface kr_rsp_if #(
  parameter int COUNT_W = 6
);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         age_out;
  logic [23:0]        class_out;
  logic [63:0]        name_out;
  logic [COUNT_W-1:0] fill_count;

  modport source (output valid, status, age_out, class_out, name_out, fill_count,
                  input ready);
  modport sink (input valid, status, age_out, class_out, name_out, fill_count,
                output ready);
endinterface

### src/keyed_record_table_compacting_top.sv
// Record table of TABLE_DEPTH entries (id, age, three-character class, eight-
// character name), kept packed at the front in arrival order as a row of cells.
// Each cell holds one record and an occupancy flag. In the cycle a transaction
// is accepted, every cell compares its id with the key in parallel and
// registers the outcome; in the next cycle a one-bit hit chain running
// through the cells picks the first match, the cells apply the add or the
// delete shift, and the response is registered. The input is ready again
// only once the table is back in its idle state and the response register
// is empty or being taken, so the table does not accept a new command
// before it is through with the last one. After reset all occupancy flags
// are cleared at once; there is no clearing pass.
module keyed_record_table_compacting_top import kr_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input logic     clk,
  input logic     rst,
  kr_cmd_if.sink  cmd,
  kr_rsp_if.source rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t     state;
  state_t     state_next;
  func_t      func_q;
  record_t    new_rec;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       load_rsp;

  // Response register. The output side stays decoupled from the command side.
  logic          rsp_valid;
  status_t       rsp_status;
  status_t       status_next;
  record_t       sel_rec;
  record_t       data_next;
  logic [7:0]    rsp_age;
  logic [23:0]   rsp_cls;
  logic [63:0]   rsp_name;
  logic [CW-1:0] rsp_count;

  record_t              rec_v [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ_v;
  logic [TABLE_DEPTH-1:0] first_v;
  logic [TABLE_DEPTH:0]   hit_v;
  logic                 found;
  logic                 full;
  logic [63:0]          cls_cut;

  assign hit_v[0] = 1'b0;
  assign found    = hit_v[TABLE_DEPTH];
  assign full     = occ_v[TABLE_DEPTH-1];

  // The row of cells. Occupancy stays contiguous from cell zero, so the first
  // free cell is found locally and the last cell takes an empty slot on shift.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic    prev_occ;
    logic    next_occ;
    record_t next_rec;

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_occ = occ_v[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_occ = 1'b0;
      assign next_rec = '0;
    end else begin : g_link
      assign next_occ = occ_v[i+1];
      assign next_rec = rec_v[i+1];
    end

    kr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .key      ($unsigned(cmd.key_id)),
      .new_rec  (new_rec),
      .prev_occ (prev_occ),
      .next_occ (next_occ),
      .next_rec (next_rec),
      .hit_in   (hit_v[i]),
      .rec      (rec_v[i]),
      .occ      (occ_v[i]),
      .hit_out  (hit_v[i+1]),
      .first    (first_v[i])
    );
  end

  // Only the first matching cell has its first flag set, so an OR over the
  // masked records selects that record.
  always_comb begin
    sel_rec = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_rec = sel_rec | (rec_v[i] & {$bits(record_t){first_v[i]}});
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    cmd.ready    = 1'b0;
    ctrl         = '0;
    load_rsp     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.ready    = !rst && (!rsp_valid || rsp.ready);
        ctrl.capture = cmd.valid && cmd.ready;
      end
      S_APPLY: begin
        ctrl.add = (func_q == FUNC_ADD);
        ctrl.del = (func_q == FUNC_DEL);
        load_rsp = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept = ctrl.capture;

  // Result of the transaction being applied.
  always_comb begin
    status_next = STAT_MISS;
    count_next  = count;
    data_next   = '0;
    case (func_q)
      FUNC_ADD: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          status_next = STAT_ADDED;
          count_next  = count + CW'(1);
        end
      end
      FUNC_FIND: begin
        if (found) begin
          status_next = STAT_FOUND;
          data_next   = sel_rec;
        end
      end
      FUNC_DEL: begin
        if (found) begin
          status_next = STAT_DELETED;
          count_next  = count - CW'(1);
        end else begin
          status_next = STAT_DEL_MISS;
        end
      end
      default: status_next = STAT_MISS;
    endcase
  end

  assign cls_cut = cut_text({40'd0, cmd.class_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q       <= func_t'(cmd.func);
      new_rec.id   <= $unsigned(cmd.key_id);
      new_rec.age  <= cmd.age_in;
      new_rec.cls  <= cls_cut[23:0];
      new_rec.name <= cut_text(cmd.name_in);
    end
    if (load_rsp) begin
      rsp_status <= status_next;
      rsp_age    <= data_next.age;
      rsp_cls    <= data_next.cls;
      rsp_name   <= data_next.name;
      rsp_count  <= count_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.age_out    = rsp_age;
  assign rsp.class_out  = rsp_cls;
  assign rsp.name_out   = rsp_name;
  assign rsp.fill_count = rsp_count;

`include "keyed_record_table_compacting_top_assert.svh"

  // Occupancy flags and the record count must always agree.
  `KR_ASSERT_NOW(a_count_matches_occ, 1'b1, $countones(occ_v) == count, "count mismatch")
  // The table never holds more records than it has cells.
  `KR_ASSERT_NOW(a_count_bounded, 1'b1, count <= CW'(TABLE_DEPTH), "count overflow")
  // An accepted transaction is applied in the next cycle with the output free.
  `KR_ASSERT_NEXT(a_accept_apply, accept, state == S_APPLY && !rsp_valid, "apply missed")
  // Applying a transaction always presents a response.
  `KR_ASSERT_NEXT(a_apply_rsp, state == S_APPLY, rsp_valid, "response missing")

endmodule

### src/kr_cell.sv
module kr_cell import kr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [31:0] key,
  input  record_t    new_rec,
  input  logic       prev_occ,
  input  logic       next_occ,
  input  record_t    next_rec,
  input  logic       hit_in,
  output record_t    rec,
  output logic       occ,
  output logic       hit_out,
  output logic       first
);

  logic match;
  logic take_new;
  logic take_next;

  // The first free cell is the one whose left neighbor is occupied.
  assign take_new  = ctrl.add && !occ && prev_occ;
  // On a delete, the matching cell and every cell behind it pull from the right.
  assign take_next = ctrl.del && (hit_in || match);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.capture) match <= occ && (rec.id == key);
      if (take_new) occ <= 1'b1;
      else if (take_next) occ <= next_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) rec <= new_rec;
    else if (take_next) rec <= next_rec;
  end

  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;

endmodule

### verif/keyed_record_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the record table, keeps a shadow copy of its
// contents, and compares every response with the one predicted for it.
module keyed_record_table_checker import kr_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  kr_cmd_if    cmd,
  kr_rsp_if    rsp,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    status_t     status;
    logic [7:0]  age;
    logic [23:0] cls;
    logic [63:0] name;
    logic [5:0]  fill;
  } table_result_t;

  record_t       shadow_rows[TABLE_DEPTH];
  int unsigned   shadow_held;
  table_result_t pending_results[$];
  int            fail_total = 0;
  int            pending_now = 0;

  assign mismatches  = fail_total;
  assign outstanding = pending_now;

  // Keeps the bytes up to the first zero byte among the low nbytes.
  function automatic logic [63:0] zero_tail(input logic [63:0] text, input int nbytes);
    logic [63:0] kept;
    logic        alive;
    kept  = '0;
    alive = 1'b1;
    for (int b = 0; b < nbytes; b++) begin
      if (text[8*b +: 8] == 8'd0) alive = 1'b0;
      if (alive) kept[8*b +: 8] = text[8*b +: 8];
    end
    return kept;
  endfunction

  // Applies one command to the shadow table and returns the response it must produce.
  function automatic table_result_t apply_command(input func_t op, input logic [31:0] id,
                                                  input logic [7:0] age,
                                                  input logic [23:0] cls,
                                                  input logic [63:0] name);
    table_result_t r;
    int            hit;
    logic [63:0]   cls_kept;
    r   = '{status: STAT_MISS, age: '0, cls: '0, name: '0, fill: '0};
    hit = -1;
    for (int i = 0; i < int'(shadow_held); i++) begin
      if (hit < 0 && shadow_rows[i].id == id) hit = i;
    end
    case (op)
      FUNC_ADD: begin
        if (shadow_held >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          cls_kept = zero_tail({40'd0, cls}, 3);
          shadow_rows[shadow_held] = '{id: id, age: age, cls: cls_kept[23:0],
                                       name: zero_tail(name, 8)};
          shadow_held++;
          r.status = STAT_ADDED;
        end
      end
      FUNC_FIND: begin
        if (hit >= 0) begin
          r.status = STAT_FOUND;
          r.age    = shadow_rows[hit].age;
          r.cls    = shadow_rows[hit].cls;
          r.name   = shadow_rows[hit].name;
        end
      end
      FUNC_DEL: begin
        if (hit >= 0) begin
          for (int j = hit; j + 1 < int'(shadow_held); j++) shadow_rows[j] = shadow_rows[j + 1];
          shadow_held--;
          r.status = STAT_DELETED;
        end else begin
          r.status = STAT_DEL_MISS;
        end
      end
      default: ;
    endcase
    r.fill = shadow_held[5:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: response mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    fail_total++;
  endtask

  task automatic check_response(input table_result_t want);
    if (rsp.status !== want.status)
      report_mismatch("status", 64'(want.status), 64'(rsp.status));
    if (rsp.age_out !== want.age)
      report_mismatch("age_out", 64'(want.age), 64'(rsp.age_out));
    if (rsp.class_out !== want.cls)
      report_mismatch("class_out", 64'(want.cls), 64'(rsp.class_out));
    if (rsp.name_out !== want.name)
      report_mismatch("name_out", want.name, rsp.name_out);
    if (rsp.fill_count !== want.fill)
      report_mismatch("fill_count", 64'(want.fill), 64'(rsp.fill_count));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_held = 0;
      pending_results.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        pending_results.push_back(apply_command(func_t'(cmd.func), cmd.key_id, cmd.age_in,
                                                cmd.class_in, cmd.name_in));
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("response with nothing expected", '0, 64'(rsp.status));
        end else begin
          check_response(pending_results.pop_front());
        end
      end
    end
    pending_now = pending_results.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Top of the record table bench. It creates the clock and the reset, drives
// commands into the table, paces the response side, and gives the verdict.
// All prediction and comparison lives in the checker instantiated beside
// the table.
module testbench;
  import kr_pkg::*;

  localparam int DEPTH      = 32;
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 111;
  // Length of the single long stall on the response side. The watchdog limit
  // is set far above it and above the longest random burst.
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 4000;
  // Wait after the final drain, covering the compare and apply steps and the
  // response register before the verdict.
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    func_t       func;
    logic [31:0] id;
    logic [7:0]  age;
    logic [23:0] cls;
    logic [63:0] name;
  } command_t;

  logic clk;
  logic rst;

  kr_cmd_if                     cmd_bus ();
  kr_rsp_if #(.COUNT_W(COUNT_W)) rsp_bus ();

  int mismatches;
  int outstanding;

  // Pacing controls. The stimulus process owns these; the response process
  // only reads them.
  logic src_idle;
  logic sink_idle;
  logic hold_kick;

  logic [31:0] key_pool[16];

  keyed_record_table_compacting_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  keyed_record_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_bus),
    .rsp         (rsp_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Response side. It stalls in random bursts while sink_idle is set, and
  // once per run it holds ready low through the long hold counted down from
  // LONG_HOLD when the stimulus toggles hold_kick. The long hold lets the table
  // fill its response register and push back on the command side.
  initial begin
    int   stall_left;
    int   hold_left;
    logic hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // The watchdog counts cycles in which neither channel completes a
  // transaction. A healthy table never goes this long without progress.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Text with zero bytes now and then, so the termination rule cuts the
  // class and the name at many different places. A quarter of the values
  // are fully random.
  function automatic logic [63:0] random_text(input int nbytes);
    logic [63:0] text;
    text = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      for (int b = 0; b < nbytes; b++) begin
        text[8*b +: 8] = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end
    end
    return text;
  endfunction

  // Draws a command with the given weights for add, find and delete. The
  // unused operation code gets a small fixed share. Keys mostly come from a
  // small pool, which gives frequent hits and duplicate ids.
  function automatic command_t random_command(input int add_w, input int find_w,
                                              input int del_w);
    command_t    c;
    int          pick;
    logic [63:0] cls_text;
    pick     = $urandom_range(0, add_w + find_w + del_w + 3 - 1);
    cls_text = random_text(3);
    if (pick < add_w) c.func = FUNC_ADD;
    else if (pick < add_w + find_w) c.func = FUNC_FIND;
    else if (pick < add_w + find_w + del_w) c.func = FUNC_DEL;
    else c.func = FUNC_NONE;
    c.id   = ($urandom_range(0, 7) == 0) ? 32'($urandom) : key_pool[$urandom_range(0, 15)];
    c.age  = 8'($urandom);
    c.cls  = cls_text[23:0];
    c.name = random_text(8);
    return c;
  endfunction

  // Offers one command and returns at the edge where it is taken. Valid
  // stays high into the next command unless an idle burst follows.
  task automatic issue(input command_t c);
    cmd_bus.valid    <= 1'b1;
    cmd_bus.func     <= c.func;
    cmd_bus.key_id   <= c.id;
    cmd_bus.age_in   <= c.age;
    cmd_bus.class_in <= c.cls;
    cmd_bus.name_in  <= c.name;
    do @(posedge clk); while (!cmd_bus.ready);
    if (src_idle && $urandom_range(0, 7) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic issue_fields(input func_t f, input logic [31:0] id, input logic [7:0] age,
                              input logic [23:0] cls, input logic [63:0] name);
    issue('{func: f, id: id, age: age, cls: cls, name: name});
  endtask

  // Stops offering and waits until every predicted response has come back.
  // The first edge lets the checker record the last accepted command.
  task automatic wait_for_drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  initial begin
    int add_w;
    int find_w;
    int del_w;

    rst              <= 1'b1;
    src_idle         <= 1'b1;
    sink_idle        <= 1'b1;
    hold_kick        <= 1'b0;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.func     <= FUNC_NONE;
    cmd_bus.key_id   <= '0;
    cmd_bus.age_in   <= '0;
    cmd_bus.class_in <= '0;
    cmd_bus.name_in  <= '0;

    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < 16; k++) key_pool[k] = $urandom;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Lookups on the empty table come first, then records
    // with extreme ids and fields, with text cut by zero bytes, and with a
    // duplicated id. Finds and deletes then hit the first copy of the
    // duplicate, the middle of the table and ids that are not there, and
    // the table is emptied again.
    issue_fields(FUNC_FIND, 32'h0000_0000, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'h0000_0000, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_NONE, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_fields(FUNC_ADD,  32'h7FFF_FFFF, 8'hFF, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_fields(FUNC_ADD,  32'h8000_0000, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_ADD,  32'h7FFF_FFFF, 8'h12, 24'h430041, 64'h1122_3344_0055_6677);
    issue_fields(FUNC_ADD,  32'h0000_0000, 8'h01, 24'h003141, 64'h0041_4243_4445_4647);
    issue_fields(FUNC_ADD,  32'hFFFF_FFFF, 8'h80, 24'hFFFF00, 64'hFFFF_FFFF_FFFF_FF00);
    issue_fields(FUNC_FIND, 32'h7FFF_FFFF, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_FIND, 32'h8000_0000, 8'hFF, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_fields(FUNC_FIND, 32'h1234_5678, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_NONE, 32'h7FFF_FFFF, 8'h55, 24'hAAAAAA, 64'h5555_AAAA_5555_AAAA);
    issue_fields(FUNC_DEL,  32'h7FFF_FFFF, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_FIND, 32'h7FFF_FFFF, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'h0000_0000, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'h1234_5678, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_FIND, 32'hFFFF_FFFF, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_FIND, 32'h0000_0000, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'h8000_0000, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'h7FFF_FFFF, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'hFFFF_FFFF, 8'h00, 24'h000000, 64'h0);
    issue_fields(FUNC_DEL,  32'hFFFF_FFFF, 8'h00, 24'h000000, 64'h0);

    // Random part in phases. Filling phases lean on adds and run the table
    // into its full state, draining phases lean on deletes and empty it, and
    // mixed phases sit between. Every fourth phase runs without idling, and
    // the last two phases run without idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0: begin add_w = 70; find_w = 15; del_w = 12; end
        1: begin add_w = 33; find_w = 35; del_w = 29; end
        default: begin add_w = 10; find_w = 25; del_w = 62; end
      endcase
      src_idle  <= (p % 4 != 3) && (p < PHASES - 2);
      sink_idle <= (p % 4 != 3) && (p < PHASES - 2);

      // Refresh part of the key pool so later phases use fresh ids, while
      // the extreme ids stay in it.
      for (int k = 4 + 4 * (p % 3); k < 8 + 4 * (p % 3); k++) key_pool[k] = $urandom;

      // Long stall on the response side while commands keep coming, so the
      // table backs up and holds its command input off.
      if (p == 3) hold_kick <= ~hold_kick;

      // Pause the command side until everything in flight has come back.
      if (p == 6 || p == 9) wait_for_drain();

      for (int n = 0; n < PHASE_LEN; n++) issue(random_command(add_w, find_w, del_w));
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
